@@ hdl/asi_pkg.sv @@
package asi_pkg;

   // Fixed geometry and blend constants
   localparam int MAX_GRID_SIDE = 4096;
   localparam int BLEND_DEPTH   = 5;
   localparam int FLUID_CELLS   = 6;

   // Q1.15 scale constants
   localparam logic [15:0] Q15_ONE  = 16'h8000;
   localparam logic [15:0] Q15_HALF = 16'h4000;

   // Remainder pipeline geometry: dividend bits, bits resolved per stage
   localparam int DIVD_W     = 20;
   localparam int DIVS_W     = 16;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = DIVD_W / DIV_STEP;

   // Field selects
   localparam logic [2:0] SEL_VX  = 3'd0;
   localparam logic [2:0] SEL_VZ  = 3'd1;
   localparam logic [2:0] SEL_TZZ = 3'd2;
   localparam logic [2:0] SEL_TXX = 3'd3;
   localparam logic [2:0] SEL_TXZ = 3'd4;
   localparam logic [2:0] SEL_END = 3'd5;

   // Source types
   localparam logic [2:0] TYP_P   = 3'd1;
   localparam logic [2:0] TYP_TXZ = 3'd2;
   localparam logic [2:0] TYP_TZZ = 3'd3;
   localparam logic [2:0] TYP_TXX = 3'd4;
   localparam logic [2:0] TYP_STRESS_MAX = 3'd5;
   localparam logic [2:0] TYP_FX  = 3'd6;
   localparam logic [2:0] TYP_FZ  = 3'd7;

   // Phases and orientations
   localparam logic [1:0] PH_FORCE  = 2'd1;
   localparam logic [1:0] PH_STRESS = 2'd2;
   localparam logic [1:0] OR_NONE   = 2'd0;
   localparam logic [1:0] OR_VDIP   = 2'd2;
   localparam logic [1:0] OR_HDIP   = 2'd3;

   // Config register indexes
   localparam logic [2:0] CSR_DELAY   = 3'd0;
   localparam logic [2:0] CSR_STRIDE  = 3'd1;
   localparam logic [2:0] CSR_LENGTH  = 3'd2;
   localparam logic [2:0] CSR_DEPTH   = 3'd3;
   localparam logic [2:0] CSR_ELASTIC = 3'd4;
   localparam logic [2:0] CSR_HSTRESS = 3'd5;
   localparam logic [2:0] CSR_SSTRESS = 3'd6;
   localparam logic [2:0] CSR_RIGID   = 3'd7;

   // One additive update
   typedef struct packed {
      logic [2:0]  sel;
      logic [23:0] addr;
      logic [31:0] delta;
   } upd_type;

   // All updates of one source, slot order is emit order
   typedef struct packed {
      upd_type [3:0] slot;
      logic [3:0]    mask;
      logic          endmark;
      logic          last_src;
   } rec_type;

endpackage

@@ hdl/asi_remdiv.sv @@
module asi_remdiv
   import asi_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              rem_zero
);

   logic [DIVS_W-1:0] rem_ff [DIV_STAGES];
   logic [DIVS_W-1:0] rem_in [DIV_STAGES];
   logic [DIVD_W-1:0] num_ff [DIV_STAGES];
   logic [DIVD_W-1:0] num_in [DIV_STAGES];
   logic [DIVS_W-1:0] dvs_ff [DIV_STAGES];
   logic [DIVS_W-1:0] dvs_in [DIV_STAGES];

   // Resolve DIV_STEP quotient bits per stage, restoring form
   always_comb begin
      logic [DIVS_W-1:0] r;
      logic [DIVD_W-1:0] n;
      logic [DIVS_W-1:0] d;
      logic [DIVS_W:0]   t;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            r = '0;
            n = dividend;
            d = divisor;
         end else begin
            r = rem_ff[s-1];
            n = num_ff[s-1];
            d = dvs_ff[s-1];
         end
         for (int b = 0; b < DIV_STEP; b++) begin
            t = {r, n[DIVD_W-1]};
            n = {n[DIVD_W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
               t = t - {1'b0, d};
            end
            r = t[DIVS_W-1:0];
         end
         rem_in[s] = r;
         num_in[s] = n;
         dvs_in[s] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            num_ff[s] <= num_in[s];
            dvs_ff[s] <= dvs_in[s];
         end
      end
   end

   assign rem_zero = (rem_ff[DIV_STAGES-1] == '0);

endmodule

@@ hdl/asi_expand.sv @@
module asi_expand
   import asi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  rec_type     in_rec,
   output logic        in_take,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,
   output logic        rsp_tlast
);

   rec_type    rec_ff;
   logic [3:0] mask_ff;
   logic [3:0] mask_in;
   logic [3:0] rest;
   upd_type    cur;

   assign rest       = mask_ff & (mask_ff - 4'd1);
   assign rsp_tvalid = (mask_ff != '0);
   assign in_take    = (mask_ff == '0) || (rsp_tready && (rest == '0));

   // Pick the lowest pending slot
   always_comb begin
      if (mask_ff[0]) begin
         cur = rec_ff.slot[0];
      end else if (mask_ff[1]) begin
         cur = rec_ff.slot[1];
      end else if (mask_ff[2]) begin
         cur = rec_ff.slot[2];
      end else begin
         cur = rec_ff.slot[3];
      end
   end

   // Load a record if empty or last beat goes, else drop the sent slot
   always_comb begin
      mask_in = mask_ff;
      if (in_take) begin
         mask_in = in_valid ? in_rec.mask : 4'd0;
      end else if (rsp_tready) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
      if (in_take && in_valid) begin
         rec_ff <= in_rec;
      end
   end

   assign rsp_tdata = {cur.delta, cur.addr};
   assign rsp_tlast = (rest == '0) && !rec_ff.endmark;
   assign rsp_tuser = {(rest == '0) && rec_ff.last_src, cur.sel};

endmodule

@@ hdl/adjoint_source_injector_top.sv @@
// Channel | Bits | Contents (lowest bit first)
// req     | tdata 88, tuser 7, tlast | one adjoint source
// rsp     | tdata 56, tuser 4, tlast | one additive update or end marker
// csr     | wen, index 3, wdata 16   | register write
//
// One source enters per cycle unless rsp stalls; a source with k updates
// holds the input while the output stage sends all but the last of them.
// From accept to first beat a source passes the input stage, five remainder
// stages of the sample check, multiply stage, update build stage and output.
// Reset is synchronous; it clears valid bits and loads register defaults.
// A stall on rsp freezes every stage together; nothing is lost or repeated.
module adjoint_source_injector_top
   import asi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // time_step[19:0], x_index[31:20], z_index[43:32], amplitude[75:44],
   // fluid_above[81:76], zero fill
   input  logic [87:0] req_tdata,
   // injection_phase[1:0], source_type[4:2], orientation[6:5]
   input  logic [6:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cell_address[23:0], delta[55:24]
   output logic [55:0] rsp_tdata,
   // field_select[2:0], end_of_step[3]
   output logic [3:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   typedef struct packed {
      logic        pre;
      logic        last;
      logic [2:0]  typ;
      logic [1:0]  orient;
      logic [11:0] x;
      logic [11:0] z;
      logic [31:0] amp;
      logic [15:0] tzq;
      logic [15:0] txq;
   } ctx_type;

   // Config registers
   logic [15:0] delay_ff, stride_ff, length_ff;
   logic [12:0] depth_ff;
   logic        elastic_ff, hstress_ff, sstress_ff, rigid_ff;
   logic [31:0] span_ff;
   logic [15:0] stride_eff;
   logic [12:0] depth_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff   <= '0;
         stride_ff  <= 16'd1;
         length_ff  <= 16'd1;
         depth_ff   <= 13'(MAX_GRID_SIDE);
         elastic_ff <= 1'b0;
         hstress_ff <= 1'b1;
         sstress_ff <= 1'b1;
         rigid_ff   <= 1'b1;
         span_ff    <= 32'd1;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_DELAY:   delay_ff   <= csr_wdata;
               CSR_STRIDE:  stride_ff  <= csr_wdata;
               CSR_LENGTH:  length_ff  <= csr_wdata;
               CSR_DEPTH:   depth_ff   <= csr_wdata[12:0];
               CSR_ELASTIC: elastic_ff <= csr_wdata[0];
               CSR_HSTRESS: hstress_ff <= csr_wdata[0];
               CSR_SSTRESS: sstress_ff <= csr_wdata[0];
               CSR_RIGID:   rigid_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         // Time steps covered by a whole trace
         span_ff <= length_ff * stride_eff;
      end
   end

   assign stride_eff = (stride_ff == '0) ? 16'd1 : stride_ff;

   always_comb begin
      if (depth_ff == '0) begin
         depth_eff = 13'd1;
      end else if (32'(depth_ff) > 32'(MAX_GRID_SIDE)) begin
         depth_eff = 13'(MAX_GRID_SIDE);
      end else begin
         depth_eff = depth_ff;
      end
   end

   // Txx blend scale for each distance to the fluid layer
   logic [15:0] txq_tab [FLUID_CELLS];
   for (genvar g = 0; g < FLUID_CELLS; g++) begin : g_txq
      assign txq_tab[g] = 16'((32768 * g + BLEND_DEPTH) / (2 * BLEND_DEPTH));
   end

   // Pipeline control
   logic    en;
   logic    take;
   logic    s0_valid_ff;
   logic    dv_valid_ff [DIV_STAGES];
   logic    m_valid_ff, f_valid_ff;
   ctx_type s0_ff, s0_in;
   logic [19:0] off_ff;
   ctx_type dv_ff [DIV_STAGES];
   ctx_type m_ff;
   logic    m_go_ff;
   logic [23:0] m_xd_ff;
   logic signed [48:0] m_ptz_ff, m_ptx_ff;
   rec_type f_ff, f_in;
   logic    rem_zero;

   assign en         = !f_valid_ff || take;
   assign req_tready = en;

   // Input stage: sample window, phase filter and blend scales
   logic [19:0] t_in;
   logic [1:0]  ph_in;
   logic [11:0] z_in;
   logic [5:0]  fl_in;
   logic [20:0] off_w;
   logic        found;
   logic [2:0]  fl_dist;

   assign t_in  = req_tdata[19:0];
   assign z_in  = req_tdata[43:32];
   assign fl_in = req_tdata[81:76];
   assign ph_in = req_tuser[1:0];
   assign off_w = {1'b0, t_in} - {5'd0, delay_ff};

   always_comb begin
      found   = 1'b0;
      fl_dist = 3'd0;
      for (int dz = 1; dz <= FLUID_CELLS; dz++) begin
         if (!found && dz <= BLEND_DEPTH + 1 && 32'(z_in) >= dz && fl_in[dz-1]) begin
            found   = 1'b1;
            fl_dist = 3'(dz - 1);
         end
      end
      s0_in.last   = req_tlast;
      s0_in.typ    = req_tuser[4:2];
      s0_in.orient = req_tuser[6:5];
      s0_in.x      = req_tdata[31:20];
      s0_in.z      = z_in;
      s0_in.amp    = req_tdata[75:44];
      s0_in.pre    = !off_w[20] && ({12'd0, off_w[19:0]} < span_ff)
                     && !(ph_in == PH_FORCE && s0_in.typ <= TYP_STRESS_MAX)
                     && !(ph_in == PH_STRESS && s0_in.typ > TYP_STRESS_MAX)
                     && (s0_in.amp != '0);
      if (elastic_ff && hstress_ff) begin
         if (rigid_ff && found) begin
            s0_in.txq = txq_tab[fl_dist];
            s0_in.tzq = Q15_ONE - txq_tab[fl_dist];
         end else begin
            s0_in.txq = Q15_HALF;
            s0_in.tzq = Q15_HALF;
         end
      end else begin
         s0_in.txq = '0;
         s0_in.tzq = Q15_ONE;
      end
   end

   // Remainder of the offset by the stride, aligned with dv_ff
   asi_remdiv u_remdiv (
      .clock    (clock),
      .en       (en),
      .dividend (off_ff),
      .divisor  (stride_eff),
      .rem_zero (rem_zero)
   );

   // Multiply stage products
   logic [24:0] xd_w;
   assign xd_w = dv_ff[DIV_STAGES-1].x * depth_eff;

   // Build stage
   logic [31:0] d_tz, d_tx, n_amp, n_tz, n_tx;
   logic [48:0] v_tz, v_tx;
   logic [23:0] a_c, a_nb;
   logic        nb_ok;

   function automatic logic [31:0] neg_sat(input logic [31:0] v);
      neg_sat = (v == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - v);
   endfunction

   always_comb begin
      v_tz  = m_ptz_ff + 49'sd16384;
      v_tx  = m_ptx_ff + 49'sd16384;
      d_tz  = v_tz[46:15];
      d_tx  = v_tx[46:15];
      n_amp = neg_sat(m_ff.amp);
      n_tz  = neg_sat(d_tz);
      n_tx  = neg_sat(d_tx);
      a_c   = m_xd_ff + 24'(m_ff.z);
      if (m_ff.orient == OR_VDIP) begin
         nb_ok = (({1'b0, m_ff.z} + 13'd1) < depth_eff);
         a_nb  = a_c + 24'd1;
      end else begin
         nb_ok = (m_ff.orient == OR_HDIP) && (m_ff.x != '0);
         a_nb  = a_c - 24'(depth_eff);
      end
      f_in          = '0;
      f_in.last_src = m_ff.last;
      if (m_go_ff) begin
         case (m_ff.typ)
            TYP_FX: begin
               f_in.slot[0] = '{SEL_VX, a_c, m_ff.amp};
               f_in.mask    = 4'b0001;
            end
            TYP_FZ: begin
               f_in.slot[0] = '{SEL_VZ, a_c, m_ff.amp};
               f_in.mask    = 4'b0001;
            end
            TYP_TZZ: begin
               f_in.slot[0] = '{SEL_TZZ, a_c, m_ff.amp};
               f_in.mask    = 4'b0001;
            end
            TYP_TXX: begin
               f_in.slot[0] = '{SEL_TXX, a_c, m_ff.amp};
               f_in.mask    = {3'b000, hstress_ff};
            end
            TYP_TXZ: begin
               f_in.slot[0] = '{SEL_TXZ, a_c, m_ff.amp};
               f_in.slot[1] = '{SEL_TXZ, a_nb, n_amp};
               f_in.mask    = {2'b00, sstress_ff && nb_ok, sstress_ff};
            end
            TYP_P: begin
               f_in.slot[0] = '{SEL_TZZ, a_c, d_tz};
               f_in.slot[1] = '{SEL_TZZ, a_nb, n_tz};
               f_in.slot[2] = '{SEL_TXX, a_c, d_tx};
               f_in.slot[3] = '{SEL_TXX, a_nb, n_tx};
               if (m_ff.orient != OR_NONE) begin
                  f_in.mask[0] = 1'b1;
                  f_in.mask[1] = nb_ok;
                  f_in.mask[2] = hstress_ff && (m_ff.txq != '0);
                  f_in.mask[3] = hstress_ff && (m_ff.txq != '0) && nb_ok;
               end
            end
            default: ;
         endcase
      end
      // End marker for a last source with nothing to send
      if (f_in.mask == '0 && m_ff.last) begin
         f_in.slot[0] = '{SEL_END, 24'd0, 32'd0};
         f_in.mask    = 4'b0001;
         f_in.endmark = 1'b1;
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         m_valid_ff  <= 1'b0;
         f_valid_ff  <= 1'b0;
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         s0_valid_ff    <= req_tvalid;
         dv_valid_ff[0] <= s0_valid_ff;
         for (int s = 1; s < DIV_STAGES; s++) begin
            dv_valid_ff[s] <= dv_valid_ff[s-1];
         end
         m_valid_ff <= dv_valid_ff[DIV_STAGES-1];
         f_valid_ff <= m_valid_ff;
      end
      if (en) begin
         s0_ff    <= s0_in;
         off_ff   <= off_w[19:0];
         dv_ff[0] <= s0_ff;
         for (int s = 1; s < DIV_STAGES; s++) begin
            dv_ff[s] <= dv_ff[s-1];
         end
         m_ff     <= dv_ff[DIV_STAGES-1];
         m_go_ff  <= dv_ff[DIV_STAGES-1].pre && rem_zero;
         m_xd_ff  <= xd_w[23:0];
         m_ptz_ff <= $signed(dv_ff[DIV_STAGES-1].amp) *
                     $signed({1'b0, dv_ff[DIV_STAGES-1].tzq});
         m_ptx_ff <= $signed(dv_ff[DIV_STAGES-1].amp) *
                     $signed({1'b0, dv_ff[DIV_STAGES-1].txq});
         f_ff     <= f_in;
      end
   end

   asi_expand u_expand (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid_ff),
      .in_rec     (f_ff),
      .in_take    (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ hdl/asi_checker.sv @@
module asi_checker
   import asi_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // Hold a stalled beat
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

   // End marker carries no update and closes the step
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == SEL_END |->
         rsp_tuser[3] && !rsp_tlast && rsp_tdata == '0)
      else $error("malformed end marker");

   // End of step only on the final beat of a source
   a_eos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tlast || rsp_tuser[2:0] == SEL_END)
      else $error("end of step before end of run");

   // No output straight after reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind adjoint_source_injector_top asi_checker u_asi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
